/* hw/rtl/pba_pkg.sv */
// Package for the packed bit-field array: sizes, command codes, register indexes and
// the structs passed between the front end, the operation queue and the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

	// Store geometry.
	localparam int WORD_COUNT = 1024;
	localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BANK_DEPTH = (WORD_COUNT + 1) / 2;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	// Field widths.
	localparam int VALUE_W    = 32;
	localparam int INDEX_W    = 16;
	localparam int BPV_W      = 6;
	localparam int ECNT_W     = 17;
	localparam int POS_W      = 22;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_VALUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT    = 2'd1;

	typedef enum logic [1:0] {
		CMD_READ    = 2'd0,
		CMD_OR      = 2'd1,
		CMD_REPLACE = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	// A classified operation, ready for the back end.
	typedef struct packed {
		cmd_t               cmd;
		logic               err;
		logic [WORD_AW-1:0] word;
		logic [5:0]         off;
		logic               straddle;
		logic [VALUE_W-1:0] mask;
		logic [VALUE_W-1:0] val;
	} op_t;

	// Status of the operation queue.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

/* hw/rtl/pba_front.sv */
// Front end of the packed bit-field array: configuration registers, input transfer and
// a two-stage classifier (bit position, range check, word split). Depends on pba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pba_front (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             push,
	output logic                            full,
	input  wire  [1:0]                      cmd,
	input  wire  [pba_pkg::INDEX_W-1:0]     index,
	input  wire  [pba_pkg::VALUE_W-1:0]     value,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [pba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [pba_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                             init_busy,
	input  pba_pkg::qstat_t                 qstat,
	output logic                            q_push,
	output pba_pkg::op_t                    q_op
);
	import pba_pkg::*;

	logic [BPV_W-1:0]   bpv_q;
	logic [ECNT_W-1:0]  ecnt_q;

	logic [BPV_W-1:0]   w_eff;
	logic [VALUE_W-1:0] mask_eff;
	logic               accept;

	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [POS_W-1:0]   pos_s1;
	logic [BPV_W-1:0]   w_s1;
	logic [VALUE_W-1:0] mask_s1;
	logic [VALUE_W-1:0] val_s1;
	logic               ierr_s1;

	logic [POS_W-1:0]   last;
	logic               advance;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpv_q  <= BPV_W'(1);
			ecnt_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BITS_PER_VALUE: bpv_q  <= cfg_data[BPV_W-1:0];
				REG_ENTRY_COUNT:    ecnt_q <= cfg_data[ECNT_W-1:0];
				default:            ;
			endcase
		end
	end

	// Effective width: zero acts as one, anything above 32 acts as 32.
	always_comb begin
		if (bpv_q == '0) begin
			w_eff = BPV_W'(1);
		end else if (bpv_q > BPV_W'(VALUE_W)) begin
			w_eff = BPV_W'(VALUE_W);
		end else begin
			w_eff = bpv_q;
		end
		mask_eff = VALUE_W'((33'(1) << w_eff) - 33'(1));
	end

	// The first stage moves on whenever the queue has room; a new item may enter then.
	assign advance = valid_s1 && !qstat.full;
	assign full    = (valid_s1 && qstat.full) || init_busy;
	assign accept  = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage one: bit position product and the entry count check.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(cmd);
			pos_s1  <= POS_W'(index) * POS_W'(w_eff);
			w_s1    <= w_eff;
			mask_s1 <= mask_eff;
			val_s1  <= value & mask_eff;
			ierr_s1 <= ECNT_W'(index) >= ecnt_q;
		end
	end

	// Stage two: store bound check, word index, offset and straddle.
	assign last   = pos_s1 + POS_W'(w_s1) - POS_W'(1);
	assign q_push = advance;

	always_comb begin
		q_op.cmd      = cmd_s1;
		q_op.err      = (cmd_s1 != CMD_CLEAR)
		                && (ierr_s1 || (32'(last >> 6) >= 32'(WORD_COUNT)));
		q_op.word     = WORD_AW'(pos_s1 >> 6);
		q_op.off      = pos_s1[5:0];
		q_op.straddle = (7'(pos_s1[5:0]) + 7'(w_s1)) > 7'd64;
		q_op.mask     = mask_s1;
		q_op.val      = val_s1;
	end

endmodule

`default_nettype wire

/* hw/rtl/pba_op_queue.sv */
// Two-entry queue of classified operations between the front end and the back end.
// Depends on pba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pba_op_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             q_push,
	input  pba_pkg::op_t    q_op,
	input  wire             q_pop,
	output pba_pkg::op_t    q_head,
	output pba_pkg::qstat_t qstat
);
	import pba_pkg::*;

	op_t        entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign qstat.full  = cnt_q == 2'd2;
	assign qstat.empty = cnt_q == 2'd0;
	assign do_push     = q_push && !qstat.full;
	assign do_pop      = q_pop && !qstat.empty;
	assign q_head      = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= q_op;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pba_back.sv */
// Back end of the packed bit-field array: even and odd word banks, the read-modify-write
// sequencer, the clearing sweep and the result register. Depends on pba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pba_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  pba_pkg::op_t                 q_head,
	input  pba_pkg::qstat_t              qstat,
	output logic                         q_pop,
	output logic                         init_busy,
	output logic                         empty,
	input  wire                          pop,
	output logic [pba_pkg::VALUE_W-1:0]  read_value,
	output logic                         range_error
);
	import pba_pkg::*;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_MOD,
		S_CLEAR
	} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [BANK_AW-1:0] sweep_q;
	logic               res_valid_q;
	logic [VALUE_W-1:0] read_value_q;
	logic               range_error_q;

	logic [63:0]        bank_even [BANK_DEPTH];
	logic [63:0]        bank_odd  [BANK_DEPTH];
	logic [63:0]        rd_even_q;
	logic [63:0]        rd_odd_q;

	logic [BANK_AW-1:0] ra_even;
	logic [BANK_AW-1:0] ra_odd;
	logic               we_even;
	logic               we_odd;
	logic [BANK_AW-1:0] wa_even;
	logic [BANK_AW-1:0] wa_odd;
	logic [63:0]        wd_even;
	logic [63:0]        wd_odd;

	logic [127:0]       old_pair;
	logic [127:0]       fld;
	logic [127:0]       msk;
	logic [127:0]       new_pair;
	logic [VALUE_W-1:0] rd_field;
	logic               do_write;
	logic               res_pop;
	logic               sweep_last;

	assign res_pop     = pop && res_valid_q;
	assign empty       = !res_valid_q;
	assign read_value  = read_value_q;
	assign range_error = range_error_q;
	assign init_busy   = state_q == S_INIT;
	assign sweep_last  = sweep_q == BANK_AW'(BANK_DEPTH - 1);

	// Take the next operation only when the result register is free or being emptied.
	assign q_pop = (state_q == S_IDLE) && !qstat.empty && (!res_valid_q || res_pop);

	// Read addresses follow the queue head; word and word + 1 sit in opposite banks.
	assign ra_odd  = BANK_AW'(q_head.word >> 1);
	assign ra_even = q_head.word[0] ? BANK_AW'((q_head.word >> 1) + WORD_AW'(1)) : ra_odd;

	// The pair {word + 1, word} as read in the previous cycle, and its update.
	always_comb begin
		old_pair = op_q.word[0] ? {rd_even_q, rd_odd_q} : {rd_odd_q, rd_even_q};
		fld      = 128'(op_q.val) << op_q.off;
		msk      = 128'(op_q.mask) << op_q.off;
		if (op_q.cmd == CMD_OR) begin
			new_pair = old_pair | fld;
		end else begin
			new_pair = (old_pair & ~msk) | fld;
		end
		rd_field = VALUE_W'(old_pair >> op_q.off) & op_q.mask;
		do_write = (state_q == S_MOD) && !op_q.err
		           && ((op_q.cmd == CMD_OR) || (op_q.cmd == CMD_REPLACE));
	end

	// Bank write ports: the sweep zeroes one row a cycle, otherwise write back the pair.
	always_comb begin
		we_even = 1'b0;
		we_odd  = 1'b0;
		wa_even = BANK_AW'(op_q.word >> 1);
		wa_odd  = BANK_AW'(op_q.word >> 1);
		wd_even = new_pair[63:0];
		wd_odd  = new_pair[127:64];
		if ((state_q == S_INIT) || (state_q == S_CLEAR)) begin
			we_even = 1'b1;
			we_odd  = 1'b1;
			wa_even = sweep_q;
			wa_odd  = sweep_q;
			wd_even = '0;
			wd_odd  = '0;
		end else if (op_q.word[0]) begin
			we_odd  = do_write;
			we_even = do_write && op_q.straddle;
			wa_even = BANK_AW'((op_q.word >> 1) + WORD_AW'(1));
			wd_odd  = new_pair[63:0];
			wd_even = new_pair[127:64];
		end else begin
			we_even = do_write;
			we_odd  = do_write && op_q.straddle;
		end
	end

	// Word banks with registered read data.
	always_ff @(posedge clk) begin
		if (we_even) begin
			bank_even[wa_even] <= wd_even;
		end
		rd_even_q <= bank_even[ra_even];
	end

	always_ff @(posedge clk) begin
		if (we_odd) begin
			bank_odd[wa_odd] <= wd_odd;
		end
		rd_odd_q <= bank_odd[ra_odd];
	end

	// Sequencer with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			sweep_q       <= '0;
			res_valid_q   <= 1'b0;
			read_value_q  <= '0;
			range_error_q <= 1'b0;
			op_q          <= '0;
		end else begin
			if (res_pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + BANK_AW'(1);
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_pop) begin
						op_q    <= q_head;
						sweep_q <= '0;
						state_q <= (q_head.cmd == CMD_CLEAR) ? S_CLEAR : S_MOD;
					end
				end
				S_MOD: begin
					res_valid_q   <= 1'b1;
					read_value_q  <= ((op_q.cmd == CMD_READ) && !op_q.err) ? rd_field : '0;
					range_error_q <= op_q.err;
					state_q       <= S_IDLE;
				end
				S_CLEAR: begin
					sweep_q <= sweep_q + BANK_AW'(1);
					if (sweep_last) begin
						sweep_q       <= '0;
						res_valid_q   <= 1'b1;
						read_value_q  <= '0;
						range_error_q <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The banks are never written while the sequencer waits for work.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(we_even || we_odd) |-> (state_q != S_IDLE))
		else $error("bank written while idle");

	// A result appears only at the end of an operation or a clear.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_MOD || state_q == S_CLEAR))
		else $error("result appeared without an operation");

	// A rejected operation never returns data.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && range_error_q) |-> (read_value_q == '0))
		else $error("range error with nonzero read value");

	// A read, OR-write or replace leaving the queue runs S_MOD and then shows a result.
	a_mod_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && (q_head.cmd != CMD_CLEAR)) |=> ##1 res_valid_q)
		else $error("operation result missing");

endmodule

`default_nettype wire

/* hw/rtl/packed_bitfield_array.sv */
// Top level of the packed bit-field array: front end, operation queue and back end.
// Depends on pba_pkg, pba_front, pba_op_queue and pba_back.
//
//   Channel   Handshake            Payload
//   input     push / full          cmd, index, value
//   result    empty / pop          read_value, range_error
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Read, OR-write and replace each do a bank read of the word pair, then a step that
// writes back (OR-write and replace only) and registers the result; the back end takes
// a new item only once done with the last. Clear-all sweeps one row of both banks per
// cycle over all BANK_DEPTH (512) rows; after reset the same pass runs, full held high.
// An item passes the stage-one register and the queue to reach the back end; a result
// waiting in the output register stalls it, and full rises once queue and stage one fill.
`timescale 1ns / 1ps
`default_nettype none

module packed_bitfield_array (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             push,
	output logic                            full,
	input  wire  [1:0]                      cmd,
	input  wire  [pba_pkg::INDEX_W-1:0]     index,
	input  wire  [pba_pkg::VALUE_W-1:0]     value,
	output logic                            empty,
	input  wire                             pop,
	output logic [pba_pkg::VALUE_W-1:0]     read_value,
	output logic                            range_error,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [pba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [pba_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pba_pkg::*;

	qstat_t qstat;
	op_t    q_op;
	op_t    q_head;
	logic   q_push;
	logic   q_pop;
	logic   init_busy;

	pba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.index     (index),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.init_busy (init_busy),
		.qstat     (qstat),
		.q_push    (q_push),
		.q_op      (q_op)
	);

	pba_op_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_op   (q_op),
		.q_pop  (q_pop),
		.q_head (q_head),
		.qstat  (qstat)
	);

	pba_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_head      (q_head),
		.qstat       (qstat),
		.q_pop       (q_pop),
		.init_busy   (init_busy),
		.empty       (empty),
		.pop         (pop),
		.read_value  (read_value),
		.range_error (range_error)
	);

endmodule

`default_nettype wire
